// File: rtl/core/tbs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbs_pkg
// Shared types and codes for the timestamp bracket search block.
// ----------------------------------------------------------------------------
package tbs_pkg;

  // Default table depth.
  localparam int unsigned TBS_DEPTH_DEF = 1024;

  // Width of the reported index fields.
  localparam int unsigned IDX_W = 10;

  // Width of a timestamp.
  localparam int unsigned STAMP_W = 64;

  // Command queue between front and back.
  localparam int unsigned CMDQ_DEPTH = 2;
  localparam int unsigned CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int unsigned CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  // Input kind codes.
  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_QUERY  = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    OP_APPEND,
    OP_QUERY,
    OP_CLEAR,
    OP_NOP
  } op_e;

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_FULL    = 3'd1,
    ST_FEW     = 3'd2,
    ST_BELOW   = 3'd3,
    ST_ABOVE   = 3'd4,
    ST_EXACT   = 3'd5,
    ST_BRACKET = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CHK_FIRST,
    BK_CHK_LAST,
    BK_SEARCH
  } bk_state_e;

  typedef struct packed {
    op_e                        op;
    logic signed [STAMP_W-1:0]  stamp;
  } cmd_t;

  typedef struct packed {
    status_e                    status;
    logic [IDX_W-1:0]           left_index;
    logic [IDX_W-1:0]           right_index;
    logic signed [STAMP_W-1:0]  left_time;
    logic signed [STAMP_W-1:0]  right_time;
  } res_t;

endpackage
`default_nettype wire

// File: rtl/core/tbs_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbs_front
// Input side: accepts transactions, decodes the kind, and buffers the
// decoded commands in a short queue for the back end.
// ----------------------------------------------------------------------------
module tbs_front
  import tbs_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire logic [1:0]                 kind_i,
  input  wire logic signed [STAMP_W-1:0]  stamp_i,
  output logic                            full_o,
  output logic                            cmd_valid_o,
  output cmd_t                            cmd_o,
  input  wire logic                       cmd_pop_i
);

  cmd_t                  q_mem [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMDQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMDQ_CNT_W-1:0] fill_q, fill_d;
  logic                  do_push, do_pop;
  cmd_t                  cmd_in;

  always_comb begin
    cmd_in.stamp = stamp_i;
    unique case (kind_i)
      KIND_APPEND: cmd_in.op = OP_APPEND;
      KIND_QUERY:  cmd_in.op = OP_QUERY;
      KIND_CLEAR:  cmd_in.op = OP_CLEAR;
      default:     cmd_in.op = OP_NOP;
    endcase
  end

  assign full_o      = (fill_q == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign cmd_valid_o = (fill_q != '0);
  assign cmd_o       = q_mem[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  // Pointers wrap at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wr_ptr_q] <= cmd_in;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/tbs_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbs_back
// Execution side: owns the timestamp table and entry count, runs appends,
// clears and the binary search, and holds the result register.
// ----------------------------------------------------------------------------
module tbs_back
  import tbs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TBS_DEPTH_DEF,
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cmd_valid_i,
  input  wire cmd_t  cmd_i,
  output logic       cmd_pop_o,
  output logic       res_valid_o,
  output res_t       res_o,
  input  wire logic  pop_i,
  output logic [CW-1:0] count_o
);

  logic signed [STAMP_W-1:0] mem [TABLE_DEPTH];
  logic signed [STAMP_W-1:0] rdata_q;
  logic [AW-1:0]             rd_addr;
  logic                      wr_en;

  bk_state_e                 state_q, state_d;
  logic [CW-1:0]             cnt_q, cnt_d;
  logic signed [STAMP_W-1:0] t_q, t_d;
  logic [AW-1:0]             lo_q, lo_d, hi_q, hi_d, probe_q, probe_d;
  logic signed [STAMP_W-1:0] lo_time_q, lo_time_d, hi_time_q, hi_time_d;
  logic                      upd_q, upd_d;
  res_t                      res_q, res_d;
  logic                      res_valid_q;
  logic                      res_load;
  logic                      slot_free;

  // Search datapath
  logic                      t_lt_v, v_lt_t, v_eq_t;
  logic [AW-1:0]             lo_n, hi_n, span, mid;
  logic signed [STAMP_W-1:0] lo_time_n, hi_time_n;

  assign slot_free   = !res_valid_q || pop_i;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign count_o     = cnt_q;

  assign t_lt_v = (t_q < rdata_q);
  assign v_lt_t = (rdata_q < t_q);
  assign v_eq_t = (rdata_q == t_q);

  // Fold the previous probe into the interval before testing it.
  always_comb begin
    lo_n      = lo_q;
    hi_n      = hi_q;
    lo_time_n = lo_time_q;
    hi_time_n = hi_time_q;
    if (upd_q) begin
      if (t_lt_v) begin
        hi_n      = probe_q;
        hi_time_n = rdata_q;
      end else begin
        lo_n      = probe_q;
        lo_time_n = rdata_q;
      end
    end
    span = hi_n - lo_n;
    mid  = lo_n + (span >> 1);
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    t_d       = t_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    lo_time_d = lo_time_q;
    hi_time_d = hi_time_q;
    probe_d   = probe_q;
    upd_d     = upd_q;
    rd_addr   = '0;
    wr_en     = 1'b0;
    cmd_pop_o = 1'b0;
    res_load  = 1'b0;
    res_d     = '{status: ST_DONE, left_index: '0, right_index: '0,
                  left_time: '0, right_time: '0};

    unique case (state_q)
      BK_IDLE: begin
        // Take a command only with the result slot free, so the
        // search can always finish.
        if (cmd_valid_i && slot_free) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.op)
            OP_APPEND: begin
              res_load = 1'b1;
              if (cnt_q == CW'(TABLE_DEPTH)) begin
                res_d.status = ST_FULL;
              end else begin
                wr_en = 1'b1;
                cnt_d = cnt_q + 1'b1;
              end
            end
            OP_CLEAR: begin
              res_load = 1'b1;
              cnt_d    = '0;
            end
            OP_QUERY: begin
              if (cnt_q < CW'(2)) begin
                res_load     = 1'b1;
                res_d.status = ST_FEW;
              end else begin
                t_d     = cmd_i.stamp;
                lo_d    = '0;
                hi_d    = AW'(cnt_q - 1'b1);
                rd_addr = '0;
                state_d = BK_CHK_FIRST;
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end

      BK_CHK_FIRST: begin
        if (t_lt_v) begin
          res_load     = 1'b1;
          res_d.status = ST_BELOW;
          state_d      = BK_IDLE;
        end else begin
          lo_time_d = rdata_q;
          rd_addr   = hi_q;
          state_d   = BK_CHK_LAST;
        end
      end

      BK_CHK_LAST: begin
        if (v_lt_t) begin
          res_load         = 1'b1;
          res_d.status     = ST_ABOVE;
          res_d.left_index = IDX_W'(hi_q);
          state_d          = BK_IDLE;
        end else begin
          // Hold the read so the last entry is the first probe.
          hi_time_d = rdata_q;
          rd_addr   = hi_q;
          probe_d   = hi_q;
          upd_d     = 1'b0;
          state_d   = BK_SEARCH;
        end
      end

      BK_SEARCH: begin
        if (v_eq_t) begin
          res_load          = 1'b1;
          res_d.status      = ST_EXACT;
          res_d.left_index  = IDX_W'(probe_q);
          res_d.right_index = IDX_W'(probe_q);
          res_d.left_time   = rdata_q;
          res_d.right_time  = rdata_q;
          state_d           = BK_IDLE;
        end else if (span == AW'(1)) begin
          res_load          = 1'b1;
          res_d.status      = ST_BRACKET;
          res_d.left_index  = IDX_W'(lo_n);
          res_d.right_index = IDX_W'(hi_n);
          res_d.left_time   = lo_time_n;
          res_d.right_time  = hi_time_n;
          state_d           = BK_IDLE;
        end else begin
          lo_d      = lo_n;
          hi_d      = hi_n;
          lo_time_d = lo_time_n;
          hi_time_d = hi_time_n;
          rd_addr   = mid;
          probe_d   = mid;
          upd_d     = 1'b1;
        end
      end

      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cnt_q       <= '0;
      upd_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      upd_q       <= upd_d;
      res_valid_q <= res_load || (res_valid_q && !pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    t_q       <= t_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    lo_time_q <= lo_time_d;
    hi_time_q <= hi_time_d;
    probe_q   <= probe_d;
    if (res_load) begin
      res_q <= res_d;
    end
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cnt_q[AW-1:0]] <= cmd_i.stamp;
    end
    rdata_q <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// File: rtl/core/timestamp_bracket_search.sv
`default_nettype none
// ----------------------------------------------------------------------------
// timestamp_bracket_search
// Table of nondecreasing timestamps with append, clear and bracketing query.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel is a queue write: drive kind_i/stamp_i with push_i; the
//    transaction is taken at a clock edge with push_i high and full_o low.
//    kind 0 appends stamp_i, 1 queries it, 2 clears the table, 3 is a no-op.
//  - Result channel is a queue read: while empty_o is low the oldest result
//    is on the status/index/time ports; pop_i takes it at a clock edge.
//  - Every input transaction gives exactly one result, in order.
//  - A two-entry command queue sits in front of the execution engine, so
//    inputs are still taken while a result waits to be popped.
//  - Append, clear, no-op and too-few results pass the command queue and
//    the result register, one per cycle while each result is popped. A
//    query runs a start step, two end checks, a test of the last entry and
//    then one halving step per probe; the loop reads one probe per cycle
//    through the table's registered read port.
//  - Items are executed one at a time; a new one starts once the result
//    register is free.
//  - Reset empties the table and both queues. Table contents are not
//    cleared; only entries below the count are ever read.
//  - If the receiver stalls, the result register holds, the engine waits,
//    and full_o rises once the command queue fills.
// ----------------------------------------------------------------------------
module timestamp_bracket_search
  import tbs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TBS_DEPTH_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // input queue
  input  wire logic                       push_i,
  output logic                            full_o,
  input  wire logic [1:0]                 kind_i,
  input  wire logic signed [STAMP_W-1:0]  stamp_i,
  // result queue
  output logic                            empty_o,
  input  wire logic                       pop_i,
  output logic [2:0]                      status_o,
  output logic [IDX_W-1:0]                left_index_o,
  output logic [IDX_W-1:0]                right_index_o,
  output logic signed [STAMP_W-1:0]       left_time_o,
  output logic signed [STAMP_W-1:0]       right_time_o
);

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  logic          cmd_valid;
  logic          cmd_pop;
  cmd_t          cmd;
  logic          res_valid;
  res_t          res;
  logic [CW-1:0] count;

  // Front: accept and decode, buffer commands.
  tbs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .kind_i      (kind_i),
    .stamp_i     (stamp_i),
    .full_o      (full_o),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // Back: table, search engine, result register.
  tbs_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_valid_o (res_valid),
    .res_o       (res),
    .pop_i       (pop_i),
    .count_o     (count)
  );

  assign empty_o       = !res_valid;
  assign status_o      = res.status;
  assign left_index_o  = res.left_index;
  assign right_index_o = res.right_index;
  assign left_time_o   = res.left_time;
  assign right_time_o  = res.right_time;

  // Entry count never runs past the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CW'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  // Results without times carry zero times.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && status_o != ST_EXACT && status_o != ST_BRACKET)
      |-> (left_time_o == '0 && right_time_o == '0 && right_index_o == '0))
    else $error("nonzero time or right index on a status without them");

  // A bracket always spans two adjacent entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && status_o == ST_BRACKET)
      |-> (right_index_o == left_index_o + 1'b1))
    else $error("bracket indices are not adjacent");

  // A clear taken by the engine leaves the table empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop && cmd.op == OP_CLEAR) |=> (count == '0))
    else $error("clear did not empty the table");

endmodule
`default_nettype wire
